@@ rtl/s2a_pkg.sv @@
// ----------------------------------------------------------------------------
// s2a_pkg
// Shared constants and key map tables for the scancode to ascii decoder.
// ----------------------------------------------------------------------------
package s2a_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 256;

   localparam logic OP_SCANCODE = 1'b0;
   localparam logic OP_READ     = 1'b1;

   localparam logic [6:0] KEY_LSHIFT = 7'h2A;
   localparam logic [6:0] KEY_RSHIFT = 7'h36;
   localparam logic [6:0] KEY_CAPS   = 7'h3A;

   function automatic logic [7:0] rom_lower(input logic [6:0] key);
      logic [7:0] ch;
      case (key)
         7'h01: ch = 8'h1B;
         7'h02: ch = 8'h31;
         7'h03: ch = 8'h32;
         7'h04: ch = 8'h33;
         7'h05: ch = 8'h34;
         7'h06: ch = 8'h35;
         7'h07: ch = 8'h36;
         7'h08: ch = 8'h37;
         7'h09: ch = 8'h38;
         7'h0A: ch = 8'h39;
         7'h0B: ch = 8'h30;
         7'h0C: ch = 8'h2D;
         7'h0D: ch = 8'h3D;
         7'h0E: ch = 8'h08;
         7'h0F: ch = 8'h09;
         7'h10: ch = 8'h71;
         7'h11: ch = 8'h77;
         7'h12: ch = 8'h65;
         7'h13: ch = 8'h72;
         7'h14: ch = 8'h74;
         7'h15: ch = 8'h79;
         7'h16: ch = 8'h75;
         7'h17: ch = 8'hFD;
         7'h18: ch = 8'h6F;
         7'h19: ch = 8'h70;
         7'h1A: ch = 8'hF0;
         7'h1B: ch = 8'hFC;
         7'h1C: ch = 8'h0A;
         7'h1E: ch = 8'h61;
         7'h1F: ch = 8'h73;
         7'h20: ch = 8'h64;
         7'h21: ch = 8'h66;
         7'h22: ch = 8'h67;
         7'h23: ch = 8'h68;
         7'h24: ch = 8'h6A;
         7'h25: ch = 8'h6B;
         7'h26: ch = 8'h6C;
         7'h27: ch = 8'hFE;
         7'h28: ch = 8'h69;
         7'h29: ch = 8'h2C;
         7'h2B: ch = 8'h3C;
         7'h2C: ch = 8'h7A;
         7'h2D: ch = 8'h78;
         7'h2E: ch = 8'h63;
         7'h2F: ch = 8'h76;
         7'h30: ch = 8'h62;
         7'h31: ch = 8'h6E;
         7'h32: ch = 8'h6D;
         7'h33: ch = 8'hF6;
         7'h34: ch = 8'hE7;
         7'h35: ch = 8'h2E;
         7'h37: ch = 8'h2A;
         7'h39: ch = 8'h20;
         7'h4E: ch = 8'h2D;
         7'h52: ch = 8'h2B;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] rom_upper(input logic [6:0] key);
      logic [7:0] ch;
      case (key)
         7'h01: ch = 8'h1B;
         7'h02: ch = 8'h21;
         7'h03: ch = 8'h40;
         7'h04: ch = 8'h23;
         7'h05: ch = 8'h24;
         7'h06: ch = 8'h25;
         7'h07: ch = 8'h5E;
         7'h08: ch = 8'h26;
         7'h09: ch = 8'h2A;
         7'h0A: ch = 8'h28;
         7'h0B: ch = 8'h29;
         7'h0C: ch = 8'h5F;
         7'h0D: ch = 8'h2B;
         7'h0E: ch = 8'h08;
         7'h0F: ch = 8'h09;
         7'h10: ch = 8'h51;
         7'h11: ch = 8'h57;
         7'h12: ch = 8'h45;
         7'h13: ch = 8'h52;
         7'h14: ch = 8'h54;
         7'h15: ch = 8'h59;
         7'h16: ch = 8'h55;
         7'h17: ch = 8'h49;
         7'h18: ch = 8'h4F;
         7'h19: ch = 8'h50;
         7'h1A: ch = 8'hC4;
         7'h1B: ch = 8'hDC;
         7'h1C: ch = 8'h0A;
         7'h1E: ch = 8'h41;
         7'h1F: ch = 8'h53;
         7'h20: ch = 8'h44;
         7'h21: ch = 8'h46;
         7'h22: ch = 8'h47;
         7'h23: ch = 8'h48;
         7'h24: ch = 8'h4A;
         7'h25: ch = 8'h4B;
         7'h26: ch = 8'h4C;
         7'h27: ch = 8'hDE;
         7'h28: ch = 8'hC5;
         7'h29: ch = 8'h3B;
         7'h2B: ch = 8'h3E;
         7'h2C: ch = 8'h5A;
         7'h2D: ch = 8'h58;
         7'h2E: ch = 8'h43;
         7'h2F: ch = 8'h56;
         7'h30: ch = 8'h42;
         7'h31: ch = 8'h4E;
         7'h32: ch = 8'h4D;
         7'h33: ch = 8'hD6;
         7'h34: ch = 8'hC3;
         7'h35: ch = 8'h3A;
         7'h37: ch = 8'h2A;
         7'h39: ch = 8'h20;
         7'h4E: ch = 8'h2D;
         7'h52: ch = 8'h2B;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

@@ rtl/scancode_to_ascii_with_fifo.sv @@
// ----------------------------------------------------------------------------
// scancode_to_ascii_with_fifo
// Decodes set 1 keyboard scancodes into characters held in a queue, and
// returns one queued character, or an empty result, for each read request.
// ----------------------------------------------------------------------------
// a read returns its character in the cycle after its transfer
// throughput: one item per cycle; a read waits only while a result is stalled
// scancodes are taken even while a result is stalled
// queue ram has one write port and one registered read port
// reset clears pointers, shift, caps and the result valid; ram is not cleared
module scancode_to_ascii_with_fifo #(
   parameter int QUEUE_DEPTH = s2a_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [7:0] req_scancode,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_character,
   output logic       rsp_queue_empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   logic [7:0]       queue_mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_next;
   logic [PTR_W-1:0] rd_next;
   logic             shift_ff, shift_in;
   logic             caps_ff, caps_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             empty_ff;
   logic [7:0]       rd_data_ff;

   logic       req_xfer;
   logic       rsp_xfer;
   logic       is_read;
   logic       is_make;
   logic [6:0] key;
   logic       letter;
   logic       upper;
   logic [7:0] dec_char;
   logic       push;
   logic       pop;
   logic       queue_empty;

   assign req_stall = rsp_valid_ff && rsp_stall && (req_opcode == s2a_pkg::OP_READ);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign is_read   = req_opcode == s2a_pkg::OP_READ;

   assign key     = req_scancode[6:0];
   assign is_make = !req_scancode[7];
   assign letter  = key inside {[7'h10:7'h19], [7'h1E:7'h26], [7'h2C:7'h32]};
   assign upper   = letter ? (shift_ff ^ caps_ff) : shift_ff;
   assign dec_char = upper ? s2a_pkg::rom_upper(key) : s2a_pkg::rom_lower(key);

   assign wr_next = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
   assign queue_empty = rd_ptr_ff == wr_ptr_ff;

   always_comb begin
      shift_in = shift_ff;
      caps_in  = caps_ff;
      push     = 1'b0;
      if (req_xfer && !is_read) begin
         if (!is_make) begin
            if (key == s2a_pkg::KEY_LSHIFT || key == s2a_pkg::KEY_RSHIFT) begin
               shift_in = 1'b0;
            end
         end else if (key == s2a_pkg::KEY_LSHIFT || key == s2a_pkg::KEY_RSHIFT) begin
            shift_in = 1'b1;
         end else if (key == s2a_pkg::KEY_CAPS) begin
            caps_in = !caps_ff;
         end else begin
            push = (dec_char != 8'h00) && (wr_next != rd_ptr_ff);
         end
      end
   end

   assign pop          = req_xfer && is_read && !queue_empty;
   assign wr_ptr_in    = push ? wr_next : wr_ptr_ff;
   assign rd_ptr_in    = pop ? rd_next : rd_ptr_ff;
   assign rsp_valid_in = (req_xfer && is_read) ? 1'b1 : (rsp_xfer ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         shift_ff     <= 1'b0;
         caps_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         shift_ff     <= shift_in;
         caps_ff      <= caps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // queue ram and result register
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= dec_char;
      end
      if (pop) begin
         rd_data_ff <= queue_mem[rd_ptr_ff];
      end
      if (req_xfer && is_read) begin
         empty_ff <= queue_empty;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_character   = empty_ff ? 8'h00 : rd_data_ff;
   assign rsp_queue_empty = empty_ff;

   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      req_xfer && is_read && queue_empty |=> rsp_valid && rsp_queue_empty
         && rsp_character == 8'h00)
      else $error("empty read did not return empty result");

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("request stalled without a pending result");

   a_scan_keeps_rd: assert property (@(posedge clock) disable iff (reset)
      req_xfer && !is_read |=> $stable(rd_ptr_ff))
      else $error("scancode transfer moved the read pointer");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> wr_next != rd_ptr_ff)
      else $error("push into a full queue");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(empty_ff))
      else $error("stalled result changed");

endmodule
